### hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // request kind carried on s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_POP
    } state_t;

endpackage

### hdl/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Loads signed values by push requests, sorts them ascending and stably with a
// bottom-up merge between two stores, and returns them by pop requests. A pop
// reads the store in an extra ST_POP state before its result is loaded. A push
// marked last starts the sort, during which s_tready is low: for n stored values
// it runs ceil(log2(n)) passes (one pass when n is 1). In each pass the single
// compare-and-write unit emits one merged value per cycle, with a ST_SETUP step
// before each run pair and at the end of the pass. The two stores swap roles
// each pass, so no copy-back pass is needed. One result is returned per request,
// in request order; the push result is returned as soon as the push is taken.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mse_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                          s_tuser,   // [0] op
    input  logic                          s_tlast,   // last_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mse_pkg::VALUE_W-1:0]   m_tdata,   // [31:0] sorted_value
    output logic [mse_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                          m_tlast    // last_out
);

    import mse_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int WW = CW + 2;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic          ready_reg, ready_next;
    logic          src_sel_reg, src_sel_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW-1:0] o_reg, o_next;

    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    status_t             m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic                  s_accept;
    logic                  out_load;
    logic [CW-1:0]         base_count;
    logic                  has_room;
    logic                  pop_ok;
    logic [CW-1:0]         rptr_inc;
    logic [WW-1:0]         rem;
    logic [WW-1:0]         w1;
    logic [WW-1:0]         w2;
    logic                  pass_last;
    logic                  take_left;
    logic                  run_done;
    logic [63:0]           push_wide;
    logic signed [63:0]    rd_wide;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] merge_data;

    logic                  load_wr;
    logic                  sort_wr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr_a;
    logic [AW-1:0]         rd_addr_b;
    logic [DATA_WIDTH-1:0] m0_rd_a, m0_rd_b, m1_rd_a, m1_rd_b;
    logic [DATA_WIDTH-1:0] rd_a, rd_b;

    mse_store #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_WIDTH)) u_main (
        .aclk      (aclk),
        .wr_en     (load_wr || (sort_wr && src_sel_reg)),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (m0_rd_a),
        .rd_data_b (m0_rd_b)
    );

    mse_store #(.DEPTH(MAX_ELEMENTS), .WIDTH(DATA_WIDTH)) u_scratch (
        .aclk      (aclk),
        .wr_en     (sort_wr && !src_sel_reg),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (m1_rd_a),
        .rd_data_b (m1_rd_b)
    );

    assign rd_a = src_sel_reg ? m1_rd_a : m0_rd_a;
    assign rd_b = src_sel_reg ? m1_rd_b : m0_rd_b;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    // a push after a finished sort starts a fresh load
    assign base_count = ready_reg ? '0 : count_reg;
    assign has_room   = base_count < CW'(MAX_ELEMENTS);
    assign pop_ok     = ready_reg && (rptr_reg < count_reg);
    assign rptr_inc   = rptr_reg + CW'(1);

    assign push_wide = 64'($signed(s_tdata));
    assign push_data = push_wide[DATA_WIDTH-1:0];
    assign rd_wide   = 64'($signed(rd_a));

    assign rem       = WW'(count_reg) - WW'(lo_reg);
    assign w1        = WW'(width_reg);
    assign w2        = WW'(width_reg) << 1;
    assign pass_last = w2 >= WW'(count_reg);

    // ties go to the left run for stability
    assign take_left  = (p_reg < mid_reg)
                        && ((q_reg >= hi_reg) || ($signed(rd_a) <= $signed(rd_b)));
    assign merge_data = take_left ? rd_a : rd_b;
    assign run_done   = (o_reg + CW'(1)) == hi_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_PUSH) begin
                        state_next = s_tlast ? ST_SETUP : ST_IDLE;
                    end else begin
                        state_next = pop_ok ? ST_POP : ST_IDLE;
                    end
                end
            end
            ST_SETUP: begin
                if (lo_reg >= count_reg && pass_last) begin
                    state_next = ST_IDLE;
                end else if (lo_reg < count_reg) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (run_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next    = count_reg;
        rptr_next     = rptr_reg;
        ready_next    = ready_reg;
        src_sel_next  = src_sel_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        o_next        = o_reg;
        out_load      = 1'b0;
        m_status_next = STATUS_OK;
        m_value_next  = '0;
        m_last_next   = 1'b0;
        load_wr       = 1'b0;
        sort_wr       = 1'b0;
        wr_addr       = base_count[AW-1:0];
        wr_data       = push_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    out_load = 1'b1;
                    if (s_tuser == OP_PUSH) begin
                        ready_next = 1'b0;
                        if (ready_reg) begin
                            rptr_next = '0;
                        end
                        if (has_room) begin
                            load_wr    = 1'b1;
                            count_next = base_count + CW'(1);
                        end else begin
                            count_next    = base_count;
                            m_status_next = STATUS_FULL;
                        end
                        if (s_tlast) begin
                            src_sel_next = 1'b0;
                            width_next   = CW'(1);
                            lo_next      = '0;
                        end
                    end else if (pop_ok) begin
                        out_load = 1'b0;
                    end else begin
                        m_status_next = STATUS_EMPTY;
                    end
                end
            end
            ST_SETUP: begin
                if (lo_reg >= count_reg) begin
                    src_sel_next = !src_sel_reg;
                    lo_next      = '0;
                    if (pass_last) begin
                        ready_next = 1'b1;
                    end else begin
                        width_next = w2[CW-1:0];
                    end
                end else begin
                    mid_next = (rem > w1) ? lo_reg + width_reg : count_reg;
                    hi_next  = (rem > w2) ? CW'(WW'(lo_reg) + w2) : count_reg;
                    p_next   = lo_reg;
                    q_next   = (rem > w1) ? lo_reg + width_reg : count_reg;
                    o_next   = lo_reg;
                end
            end
            ST_MERGE: begin
                sort_wr = 1'b1;
                wr_addr = o_reg[AW-1:0];
                wr_data = merge_data;
                o_next  = o_reg + CW'(1);
                if (take_left) begin
                    p_next = p_reg + CW'(1);
                end else begin
                    q_next = q_reg + CW'(1);
                end
                if (run_done) begin
                    lo_next = hi_reg;
                end
            end
            ST_POP: begin
                out_load     = 1'b1;
                m_value_next = rd_wide[VALUE_W-1:0];
                rptr_next    = rptr_inc;
                if (rptr_inc >= count_reg) begin
                    m_last_next = 1'b1;
                    ready_next  = 1'b0;
                    count_next  = '0;
                    rptr_next   = '0;
                end
            end
            default: ;
        endcase

        // sort reads use the next pointers, so data lines up with p and q
        if (state_reg == ST_SETUP || state_reg == ST_MERGE) begin
            rd_addr_a = p_next[AW-1:0];
        end else begin
            rd_addr_a = rptr_reg[AW-1:0];
        end
        rd_addr_b = q_next[AW-1:0];
    end

    assign m_valid_next = (m_valid_reg && !m_tready) || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rptr_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rptr_reg    <= rptr_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_sel_reg <= src_sel_next;
        width_reg   <= width_next;
        lo_reg      <= lo_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        o_reg       <= o_next;
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_value_reg  <= m_value_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // merge never runs with both runs exhausted
    a_merge_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> ((p_reg < mid_reg) || (q_reg < hi_reg)))
        else $error("merge step with no data");

    // merge writes stay inside the loaded region
    a_merge_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> ((o_reg < hi_reg) && (hi_reg <= count_reg)))
        else $error("merge write out of range");

    // read pointer never passes the count, and is zero while nothing is sorted
    a_rptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rptr_reg <= count_reg) && (ready_reg || rptr_reg == '0))
        else $error("read pointer out of range");

    // a pop that completes always leaves the block idle with a result queued
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("pop did not produce a result");

endmodule

### hdl/mse_store.sv
// ----------------------------------------------------------------------------
// mse_store
// Single-write, dual-read memory with registered read data.
// ----------------------------------------------------------------------------
module mse_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
